FILE: rtl/core/ajd_pkg.sv
// ----------------------------------------------------------------------------
// ajd_pkg
// shared types, register indexes and reset values of the jump detector
// ----------------------------------------------------------------------------
package ajd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int MAG_W    = 16;
    localparam int RAD_W    = 2 * MAG_W;
    localparam int REM_W    = MAG_W + 2;
    localparam int CFG_W    = 16;
    localparam int ALPHA_W  = 8;

    // configuration register indexes
    localparam logic [2:0] CFG_FILTER_ALPHA    = 3'd0;
    localparam logic [2:0] CFG_RISE_THRESHOLD  = 3'd1;
    localparam logic [2:0] CFG_FALL_THRESHOLD  = 3'd2;
    localparam logic [2:0] CFG_LAND_LOW        = 3'd3;
    localparam logic [2:0] CFG_LAND_HIGH       = 3'd4;
    localparam logic [2:0] CFG_MIN_DURATION_MS = 3'd5;
    localparam logic [2:0] CFG_MAX_DURATION_MS = 3'd6;
    localparam logic [2:0] CFG_COOLDOWN_MS     = 3'd7;

    // reset values
    localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA    = 8'd179;
    localparam logic [CFG_W-1:0]   RST_RISE_THRESHOLD  = 16'd6144;
    localparam logic [CFG_W-1:0]   RST_FALL_THRESHOLD  = 16'd3277;
    localparam logic [CFG_W-1:0]   RST_LAND_LOW        = 16'd3277;
    localparam logic [CFG_W-1:0]   RST_LAND_HIGH       = 16'd4915;
    localparam logic [CFG_W-1:0]   RST_MIN_DURATION_MS = 16'd80;
    localparam logic [CFG_W-1:0]   RST_MAX_DURATION_MS = 16'd1500;
    localparam logic [CFG_W-1:0]   RST_COOLDOWN_MS     = 16'd250;
    localparam logic [MAG_W-1:0]   RST_FILTER_VALUE    = 16'd4096;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_RISING   = 2'd1,
        PH_FALLING  = 2'd2,
        PH_COOLDOWN = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_SQX,
        SQ_SQY,
        SQ_SQZ,
        SQ_ROOT,
        SQ_FLTA,
        SQ_FLTB,
        SQ_DONE
    } t_seq;

endpackage

FILE: rtl/core/ajd_isqrt.sv
// ----------------------------------------------------------------------------
// ajd_isqrt
// bit-serial floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module ajd_isqrt
    import ajd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [RAD_W-1:0] i_radicand,
    output logic             o_done,
    output logic [MAG_W-1:0] o_root
);

    localparam int CNT_W = $clog2(MAG_W);

    logic [RAD_W-1:0] r_rad;
    logic [REM_W-1:0] r_rem;
    logic [MAG_W-1:0] r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [REM_W+1:0] w_rem_sh;
    logic [REM_W+1:0] w_trial;
    logic             w_fit;

    // bring down two radicand bits, try root*4+1
    assign w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(MAG_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= REM_W'(w_rem_sh);
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

FILE: rtl/core/accel_jump_detector.sv
// ----------------------------------------------------------------------------
// accel_jump_detector
// accelerometer magnitude, low-pass filter and four-phase jump detector
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in        sink       i_in_valid / o_in_ready   i_accel_x/y/z, i_time_ms
//  out       source     o_out_valid / i_out_ready o_jump_found,
//                                                 o_smoothed_magnitude, o_phase
//  cfg       sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
//  one sample passes from transfer to result through 3 squares on the
//  shared 16x16 multiplier, the bit-serial root step (16 bit-serial steps,
//  then a registered done flag), 2 filter products on the same multiplier
//  and 1 detector decision; ready returns with the result, so a new
//  sample is accepted only once the previous one has been loaded
//  the root unit, one bit a cycle, takes most of a sample's processing
//  reset is synchronous and active low; it restores register defaults,
//  the idle phase, both stamps and a filter value of 1.0 g
//  a result waits in the output register until taken; the next sample
//  is accepted meanwhile and holds in the decision step if the register
//  is still full
// ----------------------------------------------------------------------------
module accel_jump_detector
    import ajd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_idx,
    input  logic [CFG_W-1:0]           i_cfg_data,

    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic signed [SAMPLE_W-1:0] i_accel_x,
    input  logic signed [SAMPLE_W-1:0] i_accel_y,
    input  logic signed [SAMPLE_W-1:0] i_accel_z,
    input  logic [TIME_W-1:0]          i_time_ms,

    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_jump_found,
    output logic [MAG_W-1:0]           o_smoothed_magnitude,
    output logic [1:0]                 o_phase
);

    // configuration registers
    logic [ALPHA_W-1:0] r_alpha;
    logic [CFG_W-1:0]   r_rise_th;
    logic [CFG_W-1:0]   r_fall_th;
    logic [CFG_W-1:0]   r_land_low;
    logic [CFG_W-1:0]   r_land_high;
    logic [CFG_W-1:0]   r_min_dur;
    logic [CFG_W-1:0]   r_max_dur;
    logic [CFG_W-1:0]   r_cooldown;

    // detector state
    t_phase             r_phase;
    logic [TIME_W-1:0]  r_start;
    logic [TIME_W-1:0]  r_last;
    logic [MAG_W-1:0]   r_filt;

    // sample capture and sequencer
    t_seq               r_seq;
    t_seq               n_seq;
    logic [SAMPLE_W-1:0] r_ax;
    logic [SAMPLE_W-1:0] r_ay;
    logic [SAMPLE_W-1:0] r_az;
    logic [TIME_W-1:0]  r_time;
    logic [RAD_W-1:0]   r_acc;

    // output register
    logic               r_out_valid;
    logic               r_jump;
    logic [MAG_W-1:0]   r_out_mag;
    t_phase             r_out_phase;

    logic               w_accept;
    logic               w_load;
    logic               w_root_start;
    logic               w_root_done;
    logic [MAG_W-1:0]   w_root;

    logic [MAG_W-1:0]   w_mul_a;
    logic [MAG_W-1:0]   w_mul_b;
    logic [RAD_W-1:0]   w_prod;
    logic [RAD_W-1:0]   w_acc_sum;
    logic [ALPHA_W:0]   w_beta;

    logic [MAG_W-1:0]   w_f;
    logic [TIME_W-1:0]  w_dur;
    logic [TIME_W-1:0]  w_since;
    logic               w_over_max;
    logic               w_cool_ok;
    t_phase             n_phase;
    logic               n_found;

    function automatic logic [SAMPLE_W-1:0] abs16(input logic [SAMPLE_W-1:0] v);
        logic [SAMPLE_W-1:0] neg;
        neg = SAMPLE_W'(~v + 1'b1);
        return v[SAMPLE_W-1] ? neg : v;
    endfunction

    assign o_in_ready = (r_seq == SQ_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = (r_seq == SQ_DONE) && (!r_out_valid || i_out_ready);

    // ---------------------------------------------------------------
    // configuration writes
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha     <= RST_FILTER_ALPHA;
            r_rise_th   <= RST_RISE_THRESHOLD;
            r_fall_th   <= RST_FALL_THRESHOLD;
            r_land_low  <= RST_LAND_LOW;
            r_land_high <= RST_LAND_HIGH;
            r_min_dur   <= RST_MIN_DURATION_MS;
            r_max_dur   <= RST_MAX_DURATION_MS;
            r_cooldown  <= RST_COOLDOWN_MS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FILTER_ALPHA:    r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                CFG_RISE_THRESHOLD:  r_rise_th   <= i_cfg_data;
                CFG_FALL_THRESHOLD:  r_fall_th   <= i_cfg_data;
                CFG_LAND_LOW:        r_land_low  <= i_cfg_data;
                CFG_LAND_HIGH:       r_land_high <= i_cfg_data;
                CFG_MIN_DURATION_MS: r_min_dur   <= i_cfg_data;
                CFG_MAX_DURATION_MS: r_max_dur   <= i_cfg_data;
                CFG_COOLDOWN_MS:     r_cooldown  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // shared multiplier: three squares, then the two filter products
    // ---------------------------------------------------------------
    assign w_beta = (ALPHA_W+1)'(2 ** ALPHA_W) - {1'b0, r_alpha};

    always_comb begin
        unique case (r_seq)
            SQ_SQX: begin
                w_mul_a = abs16(r_ax);
                w_mul_b = abs16(r_ax);
            end
            SQ_SQY: begin
                w_mul_a = abs16(r_ay);
                w_mul_b = abs16(r_ay);
            end
            SQ_SQZ: begin
                w_mul_a = abs16(r_az);
                w_mul_b = abs16(r_az);
            end
            SQ_FLTA: begin
                // weight of the previous filter value
                w_mul_a = MAG_W'(r_alpha);
                w_mul_b = r_filt;
            end
            SQ_FLTB: begin
                // weight of the new magnitude
                w_mul_a = MAG_W'(w_beta);
                w_mul_b = w_root;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod    = w_mul_a * w_mul_b;
    assign w_acc_sum = r_acc + w_prod;

    // sum of squares goes straight into the root unit
    assign w_root_start = (r_seq == SQ_SQZ);

    ajd_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (w_acc_sum),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= SQ_IDLE;
        end else begin
            r_seq <= n_seq;
        end
    end

    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: if (w_accept) n_seq = SQ_SQX;
            SQ_SQX:  n_seq = SQ_SQY;
            SQ_SQY:  n_seq = SQ_SQZ;
            SQ_SQZ:  n_seq = SQ_ROOT;
            SQ_ROOT: if (w_root_done) n_seq = SQ_FLTA;
            SQ_FLTA: n_seq = SQ_FLTB;
            SQ_FLTB: n_seq = SQ_DONE;
            SQ_DONE: if (w_load) n_seq = SQ_IDLE;
            default: n_seq = SQ_IDLE;
        endcase
    end

    // sample capture and accumulator
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ax   <= i_accel_x;
            r_ay   <= i_accel_y;
            r_az   <= i_accel_z;
            r_time <= i_time_ms;
        end
        unique case (r_seq)
            SQ_SQX, SQ_FLTA:         r_acc <= w_prod;
            SQ_SQY, SQ_SQZ, SQ_FLTB: r_acc <= w_acc_sum;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // detector decision on the new filter value
    // ---------------------------------------------------------------
    assign w_f        = r_acc[MAG_W+ALPHA_W-1:ALPHA_W];
    assign w_dur      = r_time - r_start;
    assign w_since    = r_time - r_last;
    assign w_over_max = (w_dur > TIME_W'(r_max_dur));
    assign w_cool_ok  = (w_since >= TIME_W'(r_cooldown));

    always_comb begin
        n_phase = r_phase;
        n_found = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (w_f > r_rise_th) n_phase = PH_RISING;
            end
            PH_RISING: begin
                priority if (w_f < r_fall_th) n_phase = PH_FALLING;
                else if (w_over_max)          n_phase = PH_IDLE;
                else                          n_phase = r_phase;
            end
            PH_FALLING: begin
                priority if (w_f > r_land_low && w_f < r_land_high) begin
                    // a rejected landing still enters cooldown
                    n_phase = PH_COOLDOWN;
                    n_found = (w_dur >= TIME_W'(r_min_dur)) && !w_over_max && w_cool_ok;
                end else if (w_over_max) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase = r_phase;
                end
            end
            PH_COOLDOWN: begin
                if (w_cool_ok) n_phase = PH_IDLE;
            end
            default: n_phase = PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_start <= '0;
            r_last  <= '0;
            r_filt  <= RST_FILTER_VALUE;
        end else if (w_load) begin
            r_phase <= n_phase;
            r_filt  <= w_f;
            if (r_phase == PH_IDLE && n_phase == PH_RISING) r_start <= r_time;
            if (n_found) r_last <= r_time;
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_jump      <= n_found;
            r_out_mag   <= w_f;
            r_out_phase <= n_phase;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_jump_found         = r_jump;
    assign o_smoothed_magnitude = r_out_mag;
    assign o_phase              = r_out_phase;

`ifndef SYNTH
    // detector phase moves only when a result is loaded
    a_phase_on_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_phase != $past(r_phase)) |-> $past(w_load))
        else $error("phase changed without a result load");

    // an accepted jump always lands in cooldown
    a_found_cooldown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_jump_found) |-> (o_phase == PH_COOLDOWN))
        else $error("jump reported outside cooldown");

    // the root unit finishes only while the sequencer waits on it
    a_root_done_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_seq == SQ_ROOT))
        else $error("root done outside the root step");
`endif

endmodule
